/* sv/qare_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package qare_pkg;

  localparam int CountBits  = 16;
  localparam int QueueDepth = 2;

  localparam int DivDvdBits = 54;
  localparam int DivDsrBits = 32;
  localparam int DivQuoBits = 32;

  localparam int FullTurnQ8 = 92160;
  localparam int HalfTurnQ8 = 46080;
  localparam int UsPerS     = 1000000;

  localparam logic [15:0] TicksPerRevReset = 16'd2400;
  localparam logic [31:0] DegPerTickReset  = 32'd2516582;

  localparam logic CfgTicksPerRev   = 1'b0;
  localparam logic CfgDegreesPerTick = 1'b1;

  typedef enum logic [1:0] {
    ACT_SAMPLE  = 2'd0,
    ACT_MEASURE = 2'd1,
    ACT_CLEAR   = 2'd2
  } action_e;

  typedef struct packed {
    logic                  done;
    logic                  ovf;
    logic [DivQuoBits-1:0] quot;
    logic [DivDsrBits-1:0] rem;
  } div_res_t;

  // A ticks_per_rev of zero stands for a full 16-bit revolution.
  function automatic logic [16:0] modulus(input logic [15:0] tpr);
    return (tpr == 16'd0) ? 17'h10000 : {1'b0, tpr};
  endfunction

endpackage

`default_nettype wire

/* sv/qare_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module qare_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = qare_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q;
  logic [PtrW-1:0]  rptr_q;
  logic [CntW-1:0]  fill_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (fill_q == CntW'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue pushed while full");

endmodule

`default_nettype wire

/* sv/qare_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module qare_front #(
  parameter int COUNT_BITS = qare_pkg::CountBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            action_i,
  input  logic                  pin_a_i,
  input  logic                  pin_b_i,
  input  logic [31:0]           elapsed_us_i,
  input  logic [15:0]           ticks_per_rev_i,
  input  logic                  full_i,
  output logic                  push_o,
  output logic                  entry_meas_o,
  output logic [COUNT_BITS-1:0] entry_count_o,
  output logic [31:0]           entry_elapsed_o
);

  localparam int NW = ((COUNT_BITS > 17) ? COUNT_BITS : 17) + 2;

  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  prev_a_q, prev_a_d;
  logic                  accept;
  logic [16:0]           m;
  logic signed [NW-1:0]  cnt_s, mod_s, step_s, wrap_s;

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;
  assign m          = qare_pkg::modulus(ticks_per_rev_i);

  always_comb begin
    cnt_s = $signed(NW'(count_q));
    mod_s = $signed(NW'(m));
    if (pin_a_i == pin_b_i) begin
      step_s = cnt_s + $signed(NW'(1));
    end else begin
      step_s = cnt_s - $signed(NW'(1));
    end
    if (step_s >= mod_s) begin
      wrap_s = step_s - mod_s;
    end else if (step_s < $signed(NW'(0))) begin
      wrap_s = step_s + mod_s;
    end else begin
      wrap_s = step_s;
    end
  end

  always_comb begin
    count_d  = count_q;
    prev_a_d = prev_a_q;
    if (accept) begin
      unique case (action_i)
        qare_pkg::ACT_SAMPLE: begin
          if (pin_a_i != prev_a_q) begin
            count_d = wrap_s[COUNT_BITS-1:0];
          end
          prev_a_d = pin_a_i;
        end
        qare_pkg::ACT_CLEAR: begin
          count_d = '0;
        end
        qare_pkg::ACT_MEASURE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      prev_a_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      prev_a_q <= prev_a_d;
    end
  end

  assign push_o          = accept;
  assign entry_meas_o    = (action_i == qare_pkg::ACT_MEASURE);
  assign entry_count_o   = count_d;
  assign entry_elapsed_o = elapsed_us_i;

endmodule

`default_nettype wire

/* sv/qare_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module qare_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [qare_pkg::DivDvdBits-1:0] dividend_i,
  input  logic [qare_pkg::DivDsrBits-1:0] divisor_i,
  output qare_pkg::div_res_t              res_o
);

  localparam int QW   = qare_pkg::DivQuoBits;
  localparam int DW   = qare_pkg::DivDsrBits;
  localparam int VW   = qare_pkg::DivDvdBits;
  localparam int StpW = $clog2(QW);

  logic            busy_q, done_q, ovf_q;
  logic [StpW-1:0] step_q;
  logic [DW-1:0]   rem_q, dsr_q;
  logic [QW-1:0]   quo_q;
  logic [DW+1:0]   trial;
  logic            fits;
  logic            too_big;

  assign trial   = {1'b0, rem_q, quo_q[QW-1]} - {2'b00, dsr_q};
  assign fits    = !trial[DW+1];
  // The quotient only fits its width when the upper dividend part is below the divisor.
  assign too_big = (DW'(dividend_i[VW-1:QW]) >= divisor_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dsr_q <= divisor_i;
        if (too_big) begin
          ovf_q  <= 1'b1;
          done_q <= 1'b1;
        end else begin
          ovf_q  <= 1'b0;
          rem_q  <= DW'(dividend_i[VW-1:QW]);
          quo_q  <= dividend_i[QW-1:0];
          step_q <= '1;
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        if (fits) begin
          rem_q <= trial[DW-1:0];
        end else begin
          rem_q <= {rem_q[DW-2:0], quo_q[QW-1]};
        end
        quo_q <= {quo_q[QW-2:0], fits};
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  assign res_o = {done_q, ovf_q, quo_q, rem_q};

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q && !done_q)
    else $error("divider started while a division was still open");

endmodule

`default_nettype wire

/* sv/qare_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module qare_back #(
  parameter int COUNT_BITS = qare_pkg::CountBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [15:0]             ticks_per_rev_i,
  input  logic [31:0]             degrees_per_tick_i,
  input  logic                    entry_empty_i,
  input  logic [COUNT_BITS+32:0]  entry_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [15:0]             position_count_o,
  output logic signed [16:0]      folded_angle_o,
  output logic signed [31:0]      angular_rate_o,
  output logic signed [31:0]      angular_accel_o,
  output logic                    zero_time_flag_o
);

  localparam int ProdW = COUNT_BITS + 32;
  localparam int DvdW  = qare_pkg::DivDvdBits;
  localparam logic [31:0] AngMax = 32'h7fff_ffff;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_GO,
    ST_RED_WAIT,
    ST_FOLD_GO,
    ST_FOLD_WAIT,
    ST_ANG,
    ST_SAT,
    ST_NUM,
    ST_RATE_GO,
    ST_RATE_WAIT,
    ST_ACC_NUM,
    ST_ACC_GO,
    ST_ACC_WAIT,
    ST_DONE
  } st_e;

  st_e                          state_q;
  logic [COUNT_BITS-1:0]        cnt_q;
  logic [31:0]                  dt_q;
  logic                         calc_q, flag_q, neg_q;
  logic [16:0]                  cred_q;
  logic signed [16:0]           fold_q;
  logic [ProdW-1:0]             prod_q;
  logic signed [31:0]           ang_q, prev_q, rate_q, accel_q, nrate_q;
  logic signed [DvdW-1:0]       num_q;
  logic                         out_valid_q, out_flag_q;
  logic [15:0]                  out_pos_q;
  logic signed [16:0]           out_fold_q;
  logic signed [31:0]           out_rate_q, out_accel_q;

  logic [16:0]                  m;
  logic [COUNT_BITS-1:0]        head_cnt;
  logic [31:0]                  head_dt;
  logic                         head_meas, head_big;
  logic [DvdW-1:0]              num_mag;
  logic signed [32:0]           ang_diff, rate_diff;
  logic [16:0]                  fold_a;
  logic signed [16:0]           fold_val;
  logic                         out_free;

  logic                         div_start;
  logic [DvdW-1:0]              div_dividend;
  logic [qare_pkg::DivDsrBits-1:0] div_divisor;
  qare_pkg::div_res_t           div_res;

  function automatic logic signed [31:0] sat_quot(input logic neg, input logic ovf,
                                                  input logic [31:0] q);
    logic signed [31:0] r;
    if (ovf) begin
      r = neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (!neg) begin
      r = q[31] ? 32'sh7fff_ffff : $signed(q);
    end else begin
      r = (q > 32'h8000_0000) ? 32'sh8000_0000 : $signed(-q);
    end
    return r;
  endfunction

  assign m         = qare_pkg::modulus(ticks_per_rev_i);
  assign head_cnt  = entry_i[COUNT_BITS-1:0];
  assign head_dt   = entry_i[COUNT_BITS+31:COUNT_BITS];
  assign head_meas = entry_i[COUNT_BITS+32];
  assign head_big  = (33'(head_cnt) >= 33'(m));
  assign pop_o     = (state_q == ST_IDLE) && !entry_empty_i;
  assign out_free  = !out_valid_q || !out_stall_i;

  assign num_mag   = num_q[DvdW-1] ? unsigned'(-num_q) : unsigned'(num_q);
  assign ang_diff  = 33'(ang_q) - 33'(prev_q);
  assign rate_diff = 33'(nrate_q) - 33'(rate_q);

  assign fold_a   = div_res.quot[16:0];
  assign fold_val = (fold_a >= 17'(qare_pkg::HalfTurnQ8))
                    ? $signed(fold_a - 17'(qare_pkg::FullTurnQ8)) : $signed(fold_a);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state_q)
      ST_RED_GO: begin
        div_start    = 1'b1;
        div_dividend = DvdW'(cnt_q);
        div_divisor  = 32'(m);
      end
      ST_FOLD_GO: begin
        div_start    = 1'b1;
        div_dividend = DvdW'(cred_q) * DvdW'(qare_pkg::FullTurnQ8);
        div_divisor  = 32'(m);
      end
      ST_RATE_GO, ST_ACC_GO: begin
        div_start    = 1'b1;
        div_dividend = num_mag;
        div_divisor  = dt_q;
      end
      default: begin
      end
    endcase
  end

  qare_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .res_o      (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      dt_q        <= '0;
      calc_q      <= 1'b0;
      flag_q      <= 1'b0;
      neg_q       <= 1'b0;
      cred_q      <= '0;
      fold_q      <= '0;
      prod_q      <= '0;
      ang_q       <= '0;
      prev_q      <= '0;
      rate_q      <= '0;
      accel_q     <= '0;
      nrate_q     <= '0;
      num_q       <= '0;
      out_valid_q <= 1'b0;
      out_flag_q  <= 1'b0;
      out_pos_q   <= '0;
      out_fold_q  <= '0;
      out_rate_q  <= '0;
      out_accel_q <= '0;
    end else begin
      if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!entry_empty_i) begin
            cnt_q  <= head_cnt;
            dt_q   <= head_dt;
            calc_q <= head_meas && (head_dt != '0);
            flag_q <= head_meas && (head_dt == '0);
            if (head_big) begin
              state_q <= ST_RED_GO;
            end else begin
              cred_q  <= 17'(head_cnt);
              state_q <= ST_FOLD_GO;
            end
          end
        end
        ST_RED_GO: state_q <= ST_RED_WAIT;
        ST_RED_WAIT: begin
          if (div_res.done) begin
            cred_q  <= div_res.rem[16:0];
            state_q <= ST_FOLD_GO;
          end
        end
        ST_FOLD_GO: state_q <= ST_FOLD_WAIT;
        ST_FOLD_WAIT: begin
          if (div_res.done) begin
            fold_q  <= fold_val;
            state_q <= calc_q ? ST_ANG : ST_DONE;
          end
        end
        ST_ANG: begin
          prod_q  <= ProdW'(cnt_q) * ProdW'(degrees_per_tick_i);
          state_q <= ST_SAT;
        end
        ST_SAT: begin
          if (64'(prod_q[ProdW-1:16]) > 64'(AngMax)) begin
            ang_q <= $signed(AngMax);
          end else begin
            ang_q <= $signed(32'(prod_q[ProdW-1:16]));
          end
          state_q <= ST_NUM;
        end
        ST_NUM: begin
          num_q   <= DvdW'(ang_diff) * DvdW'(qare_pkg::UsPerS);
          state_q <= ST_RATE_GO;
        end
        ST_RATE_GO: begin
          neg_q   <= num_q[DvdW-1];
          state_q <= ST_RATE_WAIT;
        end
        ST_RATE_WAIT: begin
          if (div_res.done) begin
            nrate_q <= sat_quot(neg_q, div_res.ovf, div_res.quot);
            state_q <= ST_ACC_NUM;
          end
        end
        ST_ACC_NUM: begin
          num_q   <= DvdW'(rate_diff) * DvdW'(qare_pkg::UsPerS);
          state_q <= ST_ACC_GO;
        end
        ST_ACC_GO: begin
          neg_q   <= num_q[DvdW-1];
          state_q <= ST_ACC_WAIT;
        end
        ST_ACC_WAIT: begin
          if (div_res.done) begin
            accel_q <= sat_quot(neg_q, div_res.ovf, div_res.quot);
            rate_q  <= nrate_q;
            prev_q  <= ang_q;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_pos_q   <= 16'(cnt_q);
            out_fold_q  <= fold_q;
            out_rate_q  <= rate_q;
            out_accel_q <= accel_q;
            out_flag_q  <= flag_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign position_count_o = out_pos_q;
  assign folded_angle_o   = out_fold_q;
  assign angular_rate_o   = out_rate_q;
  assign angular_accel_o  = out_accel_q;
  assign zero_time_flag_o = out_flag_q;

  a_rate_at_accel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(rate_q) |-> $past(state_q) == ST_ACC_WAIT)
    else $error("rate changed outside the acceleration step");

  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FOLD_WAIT) && div_res.done
      |-> !div_res.ovf && (div_res.quot < 32'(qare_pkg::FullTurnQ8)))
    else $error("fold quotient beyond one turn");

endmodule

`default_nettype wire

/* sv/quadrature_angle_rate_estimator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Quadrature position, angle and rate estimator. The front end decodes each
// word in the cycle it is accepted. On a pin sample it steps the count on every
// change of channel A, and a clear word zeroes the count. It then queues the
// word for the back end; the queue holds two words. The back end works on one
// word at a time with a shared 32-step long divider. A pin sample, clear or
// unused word takes one division for the folded angle once it reaches the
// back end. A measure word with a non-zero elapsed time takes two more
// divisions by the elapsed time, for rate and acceleration. When the count
// lies at or above ticks_per_rev, a further division reduces it first. Input
// words are taken while the queue has room, and the finished result waits in
// an output register.
// Configuration writes are always ready. Write them only while the block is idle.
module quadrature_angle_rate_estimator #(
  parameter int COUNT_BITS = qare_pkg::CountBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic               pin_a_i,
  input  logic               pin_b_i,
  input  logic [31:0]        elapsed_us_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        position_count_o,
  output logic signed [16:0] folded_angle_o,
  output logic signed [31:0] angular_rate_o,
  output logic signed [31:0] angular_accel_o,
  output logic               zero_time_flag_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int EntryW = COUNT_BITS + 33;

  logic [15:0]           tpr_q;
  logic [31:0]           dpt_q;
  logic                  push;
  logic                  full;
  logic                  pop;
  logic                  empty;
  logic                  entry_meas;
  logic [COUNT_BITS-1:0] entry_count;
  logic [31:0]           entry_elapsed;
  logic [EntryW-1:0]     wdata;
  logic [EntryW-1:0]     rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpr_q <= qare_pkg::TicksPerRevReset;
      dpt_q <= qare_pkg::DegPerTickReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        qare_pkg::CfgTicksPerRev:    tpr_q <= cfg_data_i[15:0];
        qare_pkg::CfgDegreesPerTick: dpt_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  qare_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .pin_a_i         (pin_a_i),
    .pin_b_i         (pin_b_i),
    .elapsed_us_i    (elapsed_us_i),
    .ticks_per_rev_i (tpr_q),
    .full_i          (full),
    .push_o          (push),
    .entry_meas_o    (entry_meas),
    .entry_count_o   (entry_count),
    .entry_elapsed_o (entry_elapsed)
  );

  assign wdata = {entry_meas, entry_elapsed, entry_count};

  qare_fifo #(
    .WIDTH (EntryW),
    .DEPTH (qare_pkg::QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wdata),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (rdata),
    .empty_o (empty)
  );

  qare_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ticks_per_rev_i    (tpr_q),
    .degrees_per_tick_i (dpt_q),
    .entry_empty_i      (empty),
    .entry_i            (rdata),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .position_count_o   (position_count_o),
    .folded_angle_o     (folded_angle_o),
    .angular_rate_o     (angular_rate_o),
    .angular_accel_o    (angular_accel_o),
    .zero_time_flag_o   (zero_time_flag_o)
  );

endmodule

`default_nettype wire
